// ===== hdl/ddpid_pkg.sv =====
// ----------------------------------------------------------------------------
// ddpid_pkg
// Shared widths, register map and types for the differential drive PID.
// ----------------------------------------------------------------------------
package ddpid_pkg;

    localparam int SAMPLE_WIDTH = 16;

    localparam int GAIN_W  = 24;
    localparam int LIMIT_W = 16;
    localparam int INTEG_W = 32;
    localparam int DRIVE_W = 32;
    localparam int DUTY_W  = 16;

    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int DIFF_W = SAMPLE_WIDTH + 2;

    // integral + error before saturation
    localparam int ISUM_W = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;

    // products of an unsigned gain (sign bit added) and a signed operand
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + INTEG_W;
    localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;

    // one loop term (three products), and the left/right mix of two terms
    localparam int TERM_W = GAIN_W + 1 + ((DIFF_W > INTEG_W) ? DIFF_W : INTEG_W) + 2;
    localparam int MIX_W  = TERM_W + 1;

    localparam int FRAC_SHIFT = 12;
    localparam int Q_W        = MIX_W - FRAC_SHIFT;

    // configuration port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_KP_SPEED    = 3'd0;
    localparam logic [IDX_W-1:0] REG_KI_SPEED_DT = 3'd1;
    localparam logic [IDX_W-1:0] REG_KD_SPEED    = 3'd2;
    localparam logic [IDX_W-1:0] REG_KP_TURN     = 3'd3;
    localparam logic [IDX_W-1:0] REG_KI_TURN_DT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_KD_TURN     = 3'd5;
    localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT = 3'd6;

    localparam logic [GAIN_W-1:0]  KP_RESET    = 24'd191693;
    localparam logic [GAIN_W-1:0]  KI_RESET    = 24'd1597;
    localparam logic [GAIN_W-1:0]  KD_RESET    = 24'd3993600;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd25600;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } t_gains;

endpackage

// ===== hdl/ddpid_loop.sv =====
// ----------------------------------------------------------------------------
// ddpid_loop
// One PID loop: gated saturating integral update and the Q39.20 loop term.
// ----------------------------------------------------------------------------
module ddpid_loop
    import ddpid_pkg::*;
(
    input  t_gains                    i_gains,
    input  logic signed [ERR_W-1:0]   i_err,
    input  logic signed [ERR_W-1:0]   i_prev_err,
    input  logic signed [INTEG_W-1:0] i_integ,
    input  logic                      i_integ_en,
    output logic signed [INTEG_W-1:0] o_integ,
    output logic signed [TERM_W-1:0]  o_term
);

    logic signed [ISUM_W-1:0]   isum;
    logic signed [INTEG_W-1:0]  isat;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_I_W-1:0] prod_i;
    logic signed [PROD_D_W-1:0] prod_d;

    always_comb begin
        isum = ISUM_W'(i_integ) + ISUM_W'(i_err);
        // out of range when bit 31 and the bits above it are not all sign copies
        if (isum[ISUM_W-1:INTEG_W-1] != {(ISUM_W-INTEG_W+1){isum[ISUM_W-1]}}) begin
            isat = isum[ISUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                  : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            isat = isum[INTEG_W-1:0];
        end
        o_integ = i_integ_en ? isat : i_integ;
    end

    assign diff   = DIFF_W'(i_err) - DIFF_W'(i_prev_err);
    assign prod_p = $signed({1'b0, i_gains.kp}) * i_err;
    assign prod_i = $signed({1'b0, i_gains.ki}) * o_integ;
    assign prod_d = $signed({1'b0, i_gains.kd}) * diff;

    assign o_term = TERM_W'(prod_p) + TERM_W'(prod_i) + TERM_W'(prod_d);

endmodule

// ===== hdl/differential_drive_pid.sv =====
// ----------------------------------------------------------------------------
// differential_drive_pid
// Speed and turn-rate PID loops with anti-windup, mixed into left/right drive.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  -------   -------------------------   ------------------------------------
//  tick in   i_valid / o_ready           i_cmd, i_target_*, i_measured_*
//  drive out o_valid / i_ready           o_left_reverse/duty, o_right_*
//  config    APB psel/penable/pwrite     paddr, pwdata, prdata, pready
//
//  Input register, then one pass of logic into the result register. One
//  request per cycle sustained unless the output stalls; the loop from the
//  previous drives through the integral gate, the gain multipliers and the
//  rounding back to the drive registers closes in that single pass.
//  Synchronous active-low reset clears gains and limit to defaults, loop state to 0.
//  A stalled output holds; the input register keeps taking requests until
//  both stages are full.
// ----------------------------------------------------------------------------
module differential_drive_pid
    import ddpid_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_target_speed,
    input  logic signed [SAMPLE_WIDTH-1:0] i_target_turn_rate,
    input  logic signed [SAMPLE_WIDTH-1:0] i_measured_speed,
    input  logic signed [SAMPLE_WIDTH-1:0] i_measured_turn_rate,

    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_left_reverse,
    output logic [DUTY_W-1:0]              o_left_duty,
    output logic                           o_right_reverse,
    output logic [DUTY_W-1:0]              o_right_duty,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ADDR_W-1:0]              paddr,
    input  logic [DATA_W-1:0]              pwdata,
    output logic [DATA_W-1:0]              prdata,
    output logic                           pready
);

    // Q40.20 mix to Q24.8, round half away from zero, saturate to 32 bits
    function automatic logic signed [DRIVE_W-1:0] to_drive(input logic signed [MIX_W-1:0] v);
        logic             neg;
        logic [MIX_W-1:0] mag;
        logic [Q_W-1:0]   q;
        neg = v[MIX_W-1];
        mag = neg ? $unsigned(-v) : $unsigned(v);
        q   = Q_W'((mag + (MIX_W'(1) << (FRAC_SHIFT - 1))) >> FRAC_SHIFT);
        if (!neg) begin
            to_drive = (q > Q_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[DRIVE_W-1:0]);
        end else begin
            to_drive = (q > Q_W'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(q[DRIVE_W-1:0]);
        end
    endfunction

    function automatic logic [DRIVE_W-1:0] mag_of(input logic signed [DRIVE_W-1:0] d);
        mag_of = d[DRIVE_W-1] ? $unsigned(-d) : $unsigned(d);
    endfunction

    // config registers
    logic [GAIN_W-1:0]  r_kp_speed, r_ki_speed, r_kd_speed;
    logic [GAIN_W-1:0]  r_kp_turn, r_ki_turn, r_kd_turn;
    logic [LIMIT_W-1:0] r_limit;

    // input stage
    logic                           r_in_valid;
    logic                           r_cmd;
    logic signed [SAMPLE_WIDTH-1:0] r_ts, r_tt, r_ms, r_mt;

    // loop state
    logic signed [INTEG_W-1:0] r_speed_integ, r_turn_integ;
    logic signed [ERR_W-1:0]   r_prev_speed_err, r_prev_turn_err;
    logic signed [DRIVE_W-1:0] r_prev_left, r_prev_right;

    // result stage
    logic              r_out_valid;
    logic              r_left_rev, r_right_rev;
    logic [DUTY_W-1:0] r_left_duty, r_right_duty;

    logic                      out_free, move, cfg_wr;
    logic [IDX_W-1:0]          cfg_idx;
    logic signed [ERR_W-1:0]   err_speed, err_turn;
    logic                      integ_en;
    t_gains                    gains_speed, gains_turn;
    logic signed [INTEG_W-1:0] n_speed_integ, n_turn_integ;
    logic signed [TERM_W-1:0]  term_speed, term_turn;
    logic signed [DRIVE_W-1:0] n_left, n_right;
    logic [DRIVE_W-1:0]        left_mag, right_mag;

    assign out_free = !r_out_valid || i_ready;
    assign move     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_KP_SPEED:    prdata = DATA_W'(r_kp_speed);
            REG_KI_SPEED_DT: prdata = DATA_W'(r_ki_speed);
            REG_KD_SPEED:    prdata = DATA_W'(r_kd_speed);
            REG_KP_TURN:     prdata = DATA_W'(r_kp_turn);
            REG_KI_TURN_DT:  prdata = DATA_W'(r_ki_turn);
            REG_KD_TURN:     prdata = DATA_W'(r_kd_turn);
            REG_DRIVE_LIMIT: prdata = DATA_W'(r_limit);
            default:         prdata = '0;
        endcase
    end

    assign err_speed = ERR_W'(r_ts) - ERR_W'(r_ms);
    assign err_turn  = ERR_W'(r_tt) - ERR_W'(r_mt);

    // anti-windup: both previous drives strictly inside the limit
    assign integ_en = (mag_of(r_prev_left) < DRIVE_W'(r_limit))
                   && (mag_of(r_prev_right) < DRIVE_W'(r_limit));

    assign gains_speed = '{kp: r_kp_speed, ki: r_ki_speed, kd: r_kd_speed};
    assign gains_turn  = '{kp: r_kp_turn, ki: r_ki_turn, kd: r_kd_turn};

    ddpid_loop u_speed (
        .i_gains    (gains_speed),
        .i_err      (err_speed),
        .i_prev_err (r_prev_speed_err),
        .i_integ    (r_speed_integ),
        .i_integ_en (integ_en),
        .o_integ    (n_speed_integ),
        .o_term     (term_speed)
    );

    ddpid_loop u_turn (
        .i_gains    (gains_turn),
        .i_err      (err_turn),
        .i_prev_err (r_prev_turn_err),
        .i_integ    (r_turn_integ),
        .i_integ_en (integ_en),
        .o_integ    (n_turn_integ),
        .o_term     (term_turn)
    );

    assign n_left    = to_drive(MIX_W'(term_speed) - MIX_W'(term_turn));
    assign n_right   = to_drive(MIX_W'(term_speed) + MIX_W'(term_turn));
    assign left_mag  = mag_of(n_left);
    assign right_mag = mag_of(n_right);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_speed <= KP_RESET;
            r_ki_speed <= KI_RESET;
            r_kd_speed <= KD_RESET;
            r_kp_turn  <= KP_RESET;
            r_ki_turn  <= KI_RESET;
            r_kd_turn  <= KD_RESET;
            r_limit    <= LIMIT_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_KP_SPEED:    r_kp_speed <= pwdata[GAIN_W-1:0];
                REG_KI_SPEED_DT: r_ki_speed <= pwdata[GAIN_W-1:0];
                REG_KD_SPEED:    r_kd_speed <= pwdata[GAIN_W-1:0];
                REG_KP_TURN:     r_kp_turn  <= pwdata[GAIN_W-1:0];
                REG_KI_TURN_DT:  r_ki_turn  <= pwdata[GAIN_W-1:0];
                REG_KD_TURN:     r_kd_turn  <= pwdata[GAIN_W-1:0];
                REG_DRIVE_LIMIT: r_limit    <= pwdata[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_cmd <= i_cmd;
            r_ts  <= i_target_speed;
            r_tt  <= i_target_turn_rate;
            r_ms  <= i_measured_speed;
            r_mt  <= i_measured_turn_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_integ    <= '0;
            r_turn_integ     <= '0;
            r_prev_speed_err <= '0;
            r_prev_turn_err  <= '0;
            r_prev_left      <= '0;
            r_prev_right     <= '0;
        end else if (move && !r_cmd) begin
            r_speed_integ    <= n_speed_integ;
            r_turn_integ     <= n_turn_integ;
            r_prev_speed_err <= err_speed;
            r_prev_turn_err  <= err_turn;
            r_prev_left      <= n_left;
            r_prev_right     <= n_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (move) begin
            if (r_cmd) begin
                // stop: forward, zero duty on both sides
                r_left_rev   <= 1'b0;
                r_left_duty  <= '0;
                r_right_rev  <= 1'b0;
                r_right_duty <= '0;
            end else begin
                r_left_rev   <= (n_left <= 0);
                r_left_duty  <= (|left_mag[DRIVE_W-1:DUTY_W]) ? '1 : left_mag[DUTY_W-1:0];
                r_right_rev  <= (n_right <= 0);
                r_right_duty <= (|right_mag[DRIVE_W-1:DUTY_W]) ? '1 : right_mag[DUTY_W-1:0];
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_left_reverse  = r_left_rev;
    assign o_left_duty     = r_left_duty;
    assign o_right_reverse = r_right_rev;
    assign o_right_duty    = r_right_duty;

endmodule

// ===== hdl/ddpid_checker.sv =====
// ----------------------------------------------------------------------------
// ddpid_checker
// Port-level checks for the differential drive PID, bound to the top level.
// ----------------------------------------------------------------------------
module ddpid_assertions
    import ddpid_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_left_reverse,
    input logic [DUTY_W-1:0] o_left_duty,
    input logic              o_right_reverse,
    input logic [DUTY_W-1:0] o_right_duty
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_left_duty) && $stable(o_right_duty)
            && $stable(o_left_reverse) && $stable(o_right_reverse))
        else $error("result changed while stalled");

    // input side only backs up when the output is stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input not ready without output stall");

    // a fresh result follows a request taken into the input register, then moved on to the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result without matching request");

    // forward zero duty only comes from a stop, which zeroes both sides
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_left_reverse && o_left_duty == '0
            |-> !o_right_reverse && o_right_duty == '0)
        else $error("forward zero duty on one side only");

endmodule

bind differential_drive_pid ddpid_assertions u_ddpid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_left_reverse  (o_left_reverse),
    .o_left_duty     (o_left_duty),
    .o_right_reverse (o_right_reverse),
    .o_right_duty    (o_right_duty)
);
